// ----- design/assert_macros.svh -----
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is held
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// concurrent assertion, checked through reset as well
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- design/kvtp_pkg.sv -----
// shared types and constants of the key/value telemetry parser
package kvtp_pkg;

    localparam int unsigned BufferDepthDefault = 16;

    localparam int unsigned KeyW      = 7;
    localparam int unsigned ValueW    = 32;
    localparam int unsigned InTdataW  = 8;
    localparam int unsigned OutTdataW = 40;

    // ascii codes the parser reacts to
    localparam logic [7:0] CharEq    = 8'h3D;
    localparam logic [7:0] CharSemi  = 8'h3B;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharComma = 8'h2C;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharHigh  = 8'h80;

    // largest magnitude that still fits as a negative value
    localparam logic [35:0] MagLimit = 36'h0_8000_0000;

    // byte held in the input register
    typedef struct packed {
        logic                valid;
        logic [InTdataW-1:0] data;
    } t_in_item;

    // result produced by the parse core in the cycle it consumes a byte
    typedef struct packed {
        logic              fire;
        logic [KeyW-1:0]   key_code;
        logic [ValueW-1:0] value;
    } t_result;

endpackage

// ----- design/key_value_telemetry_parser_unit.sv -----
// top level of the key/value telemetry parser
//
//  channel  | dir | tdata fields (low bit up)
//  ---------+-----+---------------------------------------------
//  s_axis   | in  | in_byte [7:0]
//  m_axis   | out | key_code [6:0], value [38:7], zero [39]
//
// one byte per cycle while no result is stalled; a byte is held in the input
// register and its result, if any, is registered in the output register once the output slot is free.
// the parse state update is a single pass of add-and-compare logic.
// synchronous active-low reset clears the parse state and the head bytes.
// a stalled result holds the core; the input register still takes one
// more byte while the result waits, if it is empty.
module key_value_telemetry_parser_unit #(
    parameter int unsigned BUFFER_DEPTH = kvtp_pkg::BufferDepthDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [kvtp_pkg::InTdataW-1:0]  s_axis_tdata,   // in_byte [7:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [kvtp_pkg::OutTdataW-1:0] m_axis_tdata    // key_code [6:0], value [38:7]
);
    import kvtp_pkg::*;

    t_in_item item;
    t_result  result;
    logic     advance;

    // input register
    kvtp_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_advance     (advance),
        .o_item        (item)
    );

    // parse core
    kvtp_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_advance (advance),
        .o_result  (result)
    );

    // result register
    kvtp_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_result      (result),
        .o_advance     (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- design/kvtp_in_reg.sv -----
// input register on the slave stream side
module kvtp_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [kvtp_pkg::InTdataW-1:0] s_axis_tdata,  // in_byte [7:0]
    input  logic                         i_advance,
    output kvtp_pkg::t_in_item           o_item
);
    import kvtp_pkg::*;

    logic                r_valid;
    logic [InTdataW-1:0] r_data;

    // room when empty or when the held byte is consumed this cycle
    assign s_axis_tready = !r_valid || i_advance;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    // byte capture on each transfer
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_data <= s_axis_tdata;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;

endmodule

// ----- design/kvtp_core.sv -----
// parse state and per-byte record decoding
module kvtp_core #(
    parameter int unsigned BUFFER_DEPTH = kvtp_pkg::BufferDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kvtp_pkg::t_in_item i_item,
    input  logic               i_advance,
    output kvtp_pkg::t_result  o_result
);
    import kvtp_pkg::*;

    localparam int unsigned FillW = $clog2(BUFFER_DEPTH + 1);

    logic [KeyW-1:0]   r_key,   n_key;
    logic [FillW-1:0]  r_fill,  n_fill;
    logic [7:0]        r_head   [4];
    logic [7:0]        n_head   [4];
    logic [ValueW-1:0] r_mag,   n_mag;
    logic              r_sign,  n_sign;
    logic              r_digit, n_digit;
    logic              r_stop,  n_stop;
    logic              r_ovf,   n_ovf;

    logic [7:0]  head_z [4];
    logic [7:0]  cur;
    logic        take;
    logic        room;
    logic        low_pos;
    logic [35:0] mag_x10;

    assign cur     = i_item.data;
    assign take    = i_item.valid && i_advance;
    assign room    = r_fill < FillW'(BUFFER_DEPTH);
    assign low_pos = r_fill < FillW'(4);

    // magnitude times ten plus the new digit, by shift and add
    assign mag_x10 = 36'({r_mag, 3'b000}) + 36'({r_mag, 1'b0}) + 36'(cur[3:0]);

    // head bytes as seen after the terminating zero is written
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            head_z[i] = r_head[i];
        end
        if (low_pos) begin
            head_z[r_fill[1:0]] = 8'h00;
        end
    end

    // next state and result
    always_comb begin
        n_key    = r_key;
        n_fill   = r_fill;
        n_mag    = r_mag;
        n_sign   = r_sign;
        n_digit  = r_digit;
        n_stop   = r_stop;
        n_ovf    = r_ovf;
        for (int i = 0; i < 4; i++) begin
            n_head[i] = r_head[i];
        end
        o_result.fire     = 1'b0;
        o_result.key_code = r_key;
        o_result.value    = '0;

        if (take) begin
            if (cur == CharEq) begin
                // start of a new value
                n_fill  = '0;
                n_mag   = '0;
                n_sign  = 1'b0;
                n_digit = 1'b0;
                n_stop  = 1'b0;
                n_ovf   = 1'b0;
            end else if (cur == CharSemi) begin
                // end of record: emit unless out of range
                for (int i = 0; i < 4; i++) begin
                    n_head[i] = head_z[i];
                end
                if (!r_digit) begin
                    o_result.fire  = 1'b1;
                    o_result.value = {head_z[0], head_z[1], head_z[2], head_z[3]};
                end else if (r_ovf) begin
                    o_result.fire = 1'b0;
                end else if (r_sign) begin
                    o_result.fire  = 1'b1;
                    o_result.value = ValueW'(0) - r_mag;
                end else if (!r_mag[ValueW-1]) begin
                    o_result.fire  = 1'b1;
                    o_result.value = r_mag;
                end
                n_key = '0;
            end else if (cur inside {CharDot, CharComma}) begin
                // separators carry nothing
            end else if (room) begin
                if (cur inside {[CharZero:CharNine], CharMinus}) begin
                    // store the character and advance the parse
                    if (low_pos) begin
                        n_head[r_fill[1:0]] = cur;
                    end
                    n_fill = r_fill + FillW'(1);
                    if (!r_stop) begin
                        if (cur == CharMinus) begin
                            if (r_fill == '0) begin
                                n_sign = 1'b1;
                            end else begin
                                n_stop = 1'b1;
                            end
                        end else begin
                            n_digit = 1'b1;
                            if (!r_ovf) begin
                                if (mag_x10 > MagLimit) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_mag = mag_x10[ValueW-1:0];
                                end
                            end
                        end
                    end
                end else if (r_key == '0 && cur > CharSpace && cur < CharHigh) begin
                    // first printable byte names the key
                    n_key = cur[KeyW-1:0];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_fill  <= '0;
            r_mag   <= '0;
            r_sign  <= 1'b0;
            r_digit <= 1'b0;
            r_stop  <= 1'b0;
            r_ovf   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_head[i] <= 8'h00;
            end
        end else begin
            r_key   <= n_key;
            r_fill  <= n_fill;
            r_mag   <= n_mag;
            r_sign  <= n_sign;
            r_digit <= n_digit;
            r_stop  <= n_stop;
            r_ovf   <= n_ovf;
            for (int i = 0; i < 4; i++) begin
                r_head[i] <= n_head[i];
            end
        end
    end

endmodule

// ----- design/kvtp_out_reg.sv -----
// result register on the master stream side
module kvtp_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kvtp_pkg::t_result             i_result,
    output logic                          o_advance,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [kvtp_pkg::OutTdataW-1:0] m_axis_tdata
);
    import kvtp_pkg::*;

    logic                 r_valid;
    logic [OutTdataW-1:0] r_data;

    // the slot frees when empty or when its transfer completes
    assign o_advance = !r_valid || m_axis_tready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_result.fire;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_advance && i_result.fire) begin
            r_data <= {1'b0, i_result.value, i_result.key_code};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

// ----- design/kvtp_checker.sv -----
// port-level checks of the parser top level
`include "assert_macros.svh"

module kvtp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [kvtp_pkg::InTdataW-1:0]  s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [kvtp_pkg::OutTdataW-1:0] m_axis_tdata
);
    logic unused_in;

    assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

    // input backpressure only while a result is stalled
    `ASSERT_CLK_RST(a_ready_low_only_on_stall, i_clk, i_rst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    // no result straight out of reset
    `ASSERT_CLK(a_no_result_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid)
    // a stalled result stays offered
    `ASSERT_CLK_RST(a_out_valid_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    // a stalled result keeps its payload
    `ASSERT_CLK_RST(a_out_data_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

endmodule

bind key_value_telemetry_parser_unit kvtp_checker u_kvtp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/key_value_telemetry_parser_unit_checker.sv -----
// checker that predicts and compares the parser's result transfers
`timescale 1ns / 1ps

module key_value_telemetry_parser_unit_checker #(
    parameter int unsigned BufferDepth = kvtp_pkg::BufferDepthDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [kvtp_pkg::InTdataW-1:0]  i_s_tdata,   // in_byte [7:0]
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [kvtp_pkg::OutTdataW-1:0] i_m_tdata,   // key_code [6:0], value [38:7]
    output int                             o_mismatch_count,
    output int                             o_open_count
);
    import kvtp_pkg::*;

    typedef struct packed {
        logic [KeyW-1:0]   key_code;
        logic [ValueW-1:0] value;
    } reading_t;

    // readings predicted but not yet seen on the output
    reading_t expected_readings[$];

    // shadow of the parser state
    logic [KeyW-1:0]   key_char;
    int unsigned       held_count;
    logic [7:0]        head_bytes[4];
    logic [ValueW-1:0] magnitude;
    bit                neg_sign;
    bit                saw_digit;
    bit                parse_stopped;
    bit                mag_overflow;

    int mismatches = 0;
    int waiting    = 0;

    assign o_mismatch_count = mismatches;
    assign o_open_count     = waiting;

    task automatic restart_number();
        held_count    = 0;
        magnitude     = '0;
        neg_sign      = 1'b0;
        saw_digit     = 1'b0;
        parse_stopped = 1'b0;
        mag_overflow  = 1'b0;
    endtask

    // one input byte through the parser, queueing a reading on a terminator
    task automatic parse_telemetry_byte(input logic [7:0] c);
        logic [35:0]       grown;
        logic [ValueW-1:0] v;
        bit                send;
        int unsigned       pos;
        reading_t          r;
        if (c == CharEq) begin
            restart_number();
        end else if (c == CharSemi) begin
            if (held_count < 4) head_bytes[held_count] = 8'h00;
            send = 1'b1;
            v    = '0;
            if (!saw_digit) begin
                // no digit: the head of the store shows through
                v = {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]};
            end else if (mag_overflow) begin
                send = 1'b0;
            end else if (neg_sign) begin
                v = 32'd0 - magnitude;
            end else if (magnitude > 32'h7FFF_FFFF) begin
                send = 1'b0;
            end else begin
                v = magnitude;
            end
            if (send) begin
                r.key_code = key_char;
                r.value    = v;
                expected_readings.push_back(r);
            end
            key_char = '0;
        end else if (c == CharDot || c == CharComma) begin
            // separators are dropped
        end else if (held_count < BufferDepth) begin
            if ((c >= CharZero && c <= CharNine) || c == CharMinus) begin
                pos = held_count;
                if (pos < 4) head_bytes[pos] = c;
                held_count = pos + 1;
                if (!parse_stopped) begin
                    if (c == CharMinus) begin
                        // a sign only counts at the front
                        if (pos == 0) neg_sign = 1'b1;
                        else parse_stopped = 1'b1;
                    end else begin
                        saw_digit = 1'b1;
                        if (!mag_overflow) begin
                            grown = {4'd0, magnitude} * 36'd10 + {28'd0, c - CharZero};
                            if (grown > MagLimit) mag_overflow = 1'b1;
                            else magnitude = grown[ValueW-1:0];
                        end
                    end
                end
            end else if (key_char == '0 && c > CharSpace && c < CharHigh) begin
                key_char = c[KeyW-1:0];
            end
        end
    endtask

    // compare result transfers, then predict from input transfers
    always @(posedge i_clk) begin : watch
        reading_t got;
        reading_t want;
        if (!i_rst_n) begin
            key_char = '0;
            for (int i = 0; i < 4; i++) head_bytes[i] = 8'h00;
            restart_number();
            expected_readings.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.key_code = i_m_tdata[KeyW-1:0];
                got.value    = i_m_tdata[KeyW +: ValueW];
                if (expected_readings.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result key %h value %0d",
                                 $realtime, got.key_code, $signed(got.value));
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got != want || i_m_tdata[OutTdataW-1] !== 1'b0) begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch exp key %h value %0d, got key %h value %0d pad %b",
                                     $realtime, want.key_code, $signed(want.value),
                                     got.key_code, $signed(got.value),
                                     i_m_tdata[OutTdataW-1]);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) parse_telemetry_byte(i_s_tdata);
            waiting = expected_readings.size();
        end
    end

endmodule

// ----- tb/key_value_telemetry_parser_unit_tb.sv -----
// testbench top: byte stream stimulus, flow pacing and verdict for the parser
`timescale 1ns / 1ps

module key_value_telemetry_parser_unit_tb;
    import kvtp_pkg::*;

    localparam int unsigned BufferDepth = BufferDepthDefault;
    localparam int ItemTarget  = 1050;
    localparam int HoldAt      = 300;
    localparam int LongHold    = 300;
    localparam int TailLen     = 150;
    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 16;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InTdataW-1:0]  s_axis_tdata  = '0;   // in_byte [7:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutTdataW-1:0] m_axis_tdata;          // key_code [6:0], value [38:7]

    logic hold_request = 1'b0;
    logic tail_quiet   = 1'b0;

    int mismatch_count;
    int open_count;

    logic [7:0] stream_bytes[$];

    always #5 i_clk = ~i_clk;

    key_value_telemetry_parser_unit #(
        .BUFFER_DEPTH (BufferDepth)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    key_value_telemetry_parser_unit_checker #(
        .BufferDepth (BufferDepth)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .o_mismatch_count (mismatch_count),
        .o_open_count     (open_count)
    );

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
    endtask

    // one record, mostly well formed, sometimes noise or boundary values
    task automatic append_record();
        int         kind;
        int         n_digits;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 6)) begin
                b = 8'($urandom_range(0, 255));
                stream_bytes.push_back(b);
            end
        end else if (kind < 13) begin
            b = 8'($urandom_range(8'h41, 8'h7F));
            stream_bytes.push_back(b);
            case ($urandom_range(0, 3))
                0: push_text("=2147483647;");
                1: push_text("=2147483648;");
                2: push_text("=-2147483648;");
                default: push_text("=-2147483649;");
            endcase
        end else begin
            // optional key, optional separator, usually an equals sign, then the number
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(8'h21, 8'h2F));
                else b = 8'($urandom_range(8'h41, 8'h7F));
                stream_bytes.push_back(b);
            end
            if ($urandom_range(0, 9) == 0)
                stream_bytes.push_back($urandom_range(0, 1) ? CharDot : CharComma);
            if ($urandom_range(0, 9) != 0) stream_bytes.push_back(CharEq);
            if ($urandom_range(0, 3) == 0) stream_bytes.push_back(CharMinus);
            n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20)
                                                    : $urandom_range(0, 10);
            for (int i = 0; i < n_digits; i++) begin
                // occasional stray byte inside the number
                if ($urandom_range(0, 29) == 0) begin
                    if ($urandom_range(0, 1)) b = CharMinus;
                    else b = 8'($urandom_range(0, 255));
                    stream_bytes.push_back(b);
                end
                if (n_digits == 10 && i == 0) b = CharZero + 8'($urandom_range(1, 2));
                else b = CharZero + 8'($urandom_range(0, 9));
                stream_bytes.push_back(b);
            end
            stream_bytes.push_back(CharSemi);
            if ($urandom_range(0, 19) == 0) stream_bytes.push_back(CharSemi);
        end
    endtask

    // byte source
    initial begin : source
        bit source_gaps;
        source_gaps = 1'b0;

        // directed: top byte never a key, most negative value,
        // separators ignored with a stale head readout, low and high bytes,
        // a minus inside the number stopping the parse
        stream_bytes.push_back(8'hFF);
        push_text("=-2147483648;");
        push_text("~.,=;");
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(CharSpace);
        stream_bytes.push_back(CharHigh);
        push_text("Z=9-7;");
        while (stream_bytes.size() < ItemTarget) append_record();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int idx = 0; idx < stream_bytes.size(); idx++) begin
            if (idx == HoldAt) hold_request <= 1'b1;
            if (idx == stream_bytes.size() - TailLen) tail_quiet <= 1'b1;
            if (idx % 64 == 0) source_gaps = 1'($urandom_range(0, 1));
            if (!tail_quiet && source_gaps && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stream_bytes[idx];
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;

        while (open_count != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("key_value_telemetry_parser_unit_tb: done, clean");
        else
            $display("key_value_telemetry_parser_unit_tb: done, errors");
        $finish;
    end

    // result sink pacing, with one long hold-off to back up the input
    initial begin : sink
        int stall_left;
        int cycle_no;
        bit sink_gaps;
        bit hold_done;
        stall_left = 0;
        cycle_no   = 0;
        sink_gaps  = 1'b0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle_no++;
            if (cycle_no % 200 == 0) sink_gaps = 1'($urandom_range(0, 1));
            if (hold_request && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LongHold - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!tail_quiet && sink_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = int'($urandom_range(0, 14));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("key_value_telemetry_parser_unit_tb: done, errors");
        $finish;
    end

endmodule
